[rtl/sc2a_pkg.sv]
// shared types, scan codes and translation tables for the scan-code set 1 translator
// no dependencies; used by sc2a_xlate and scancode_to_ascii_with_fifo_top
package sc2a_pkg;

	// default queue depth; the queue holds one character less
	localparam int QUEUE_DEPTH_DEF = 32;

	// make codes at or above this length have no table entry
	localparam int XLATE_LEN = 99;

	// operation codes
	typedef enum logic {
		OP_KEY  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef logic [7:0] char_t;

	// scan codes with a fixed meaning
	localparam char_t SC_PREFIX     = 8'hE0;
	localparam char_t SC_LSHIFT     = 8'h2A;
	localparam char_t SC_RSHIFT     = 8'h36;
	localparam char_t SC_LSHIFT_BRK = 8'hAA;
	localparam char_t SC_RSHIFT_BRK = 8'hB6;
	localparam char_t SC_ALT        = 8'h38;
	localparam char_t SC_ALT_BRK    = 8'hB8;
	localparam char_t SC_CTRL       = 8'h1D;
	localparam char_t SC_CTRL_BRK   = 8'h9D;
	localparam char_t SC_SCROLL     = 8'h46;
	localparam char_t SC_CAPS       = 8'h3A;
	localparam char_t SC_NUM        = 8'h45;
	localparam char_t SC_SCROLL_BRK = 8'hC6;
	localparam char_t SC_NUM_BRK    = 8'hC5;
	localparam char_t SC_CAPS_BRK   = 8'hBA;

	// low seven bits of the codes that may follow the prefix byte
	localparam logic [6:0] EXT_ALT      = 7'h38;
	localparam logic [6:0] EXT_CTRL     = 7'h1D;
	localparam logic [6:0] EXT_KP_SLASH = 7'h35;
	localparam logic [6:0] EXT_KP_ENTER = 7'h1C;

	// table entry that stands for no character
	localparam char_t NO_CHAR = 8'hFF;

	// modifier state seen by the translator
	typedef struct packed {
		logic shift;
		logic ctrl;
		logic caps;
	} mods_t;

	// plain table, padded with no-character entries to 128
	localparam char_t TBL_PLAIN [128] = '{
		8'hFF, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'hFF, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'hFF, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'hFF, 8'hFF,
		8'hFF, 8'h20, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h37,
		8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2E, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'h0D, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
	};

	// shift table
	localparam char_t TBL_SHIFT [128] = '{
		8'hFF, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'hFF, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'hFF, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'hFF, 8'hFF,
		8'hFF, 8'h20, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h37,
		8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2E, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'h0D, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
	};

	// ctrl table
	localparam char_t TBL_CTRL [128] = '{
		8'hFF, 8'h1B, 8'h31, 8'h00, 8'h33, 8'h34, 8'h35, 8'h1E,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h1F, 8'h3D, 8'h08, 8'h09,
		8'h11, 8'h17, 8'h05, 8'h12, 8'h14, 8'h18, 8'h15, 8'h09,
		8'h0F, 8'h10, 8'h1B, 8'h1D, 8'h0A, 8'hFF, 8'h01, 8'h13,
		8'h04, 8'h06, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h3B,
		8'h27, 8'h7E, 8'h00, 8'h1C, 8'h1A, 8'h18, 8'h03, 8'h16,
		8'h02, 8'h0E, 8'h0D, 8'h3C, 8'h3E, 8'h3F, 8'hFF, 8'hFF,
		8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h37,
		8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2E, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'h0D, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
	};

endpackage

[rtl/sc2a_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module sc2a_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/sc2a_xlate.sv]
// make code to character lookup through the plain, shift and ctrl tables
// depends on sc2a_pkg
module sc2a_xlate (
	input  logic [6:0]      make_code,
	input  sc2a_pkg::mods_t mods,
	output sc2a_pkg::char_t kc
);
	import sc2a_pkg::*;

	char_t plain_c;
	char_t shift_c;
	char_t ctrl_c;

	assign plain_c = TBL_PLAIN[make_code];
	assign shift_c = TBL_SHIFT[make_code];
	assign ctrl_c  = TBL_CTRL[make_code];

	// ctrl over shift, shift over caps; caps touches letters only
	always_comb begin
		kc = plain_c;
		if (mods.caps && shift_c >= 8'h41 && shift_c <= 8'h5A) begin
			kc = shift_c;
		end
		if (mods.shift) begin
			kc = shift_c;
		end
		if (mods.ctrl) begin
			kc = ctrl_c;
		end
	end

endmodule

[rtl/scancode_to_ascii_with_fifo_top.sv]
// top level of the scan-code set 1 to character translator with its character queue
// depends on sc2a_pkg, sc2a_xlate and sc2a_ram
//
// Takes one transfer per clock when not stalled: a keyboard byte (op 0) updates the
// prefix, modifier and lock state and may push one translated character, a read
// (op 1) pops one. Every transfer gives exactly one result in the next cycle, the
// cycle of the registered read of the character ram. The result register and the
// input side work together, so a new transfer is taken while the previous result
// is taken from the output; item_stall rises only while a finished result is held
// by result_stall. The queue holds QUEUE_DEPTH - 1 characters and drops newer
// characters when full. led_bits always shows the lock state after the step.
module scancode_to_ascii_with_fifo_top #(
	parameter int QUEUE_DEPTH = sc2a_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  op,
	input  sc2a_pkg::char_t       scan_byte,
	input  logic                  rx_error,
	input  logic                  from_aux,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  char_valid,
	output sc2a_pkg::char_t       char_code,
	output logic                  queue_nonempty,
	output logic                  dropped_full,
	output logic                  led_update,
	output logic [2:0]            led_bits
);
	import sc2a_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
	localparam logic [AW-1:0] IDX_ONE  = AW'(1);

	// keyboard state
	logic prefix_q, shift_q, ctrl_q, alt_q, caps_q, num_q, scroll_q;
	logic prefix_d, shift_d, ctrl_d, alt_d, caps_d, num_d, scroll_d;
	logic [AW-1:0] wr_q, rd_q, wr_d, rd_d;
	logic [AW-1:0] wr_next, rd_next;

	// per-transfer results
	logic fire;
	logic push, pop, drop, ledup;
	logic ext_ok;
	char_t kc;
	mods_t mods;

	// result register
	logic out_valid_q;
	logic char_valid_s1, nonempty_s1, dropped_s1, ledup_s1;
	logic [2:0] led_s1;
	char_t ram_rdata;

	// handshake
	assign item_stall = out_valid_q & result_stall;
	assign fire       = item_valid & ~item_stall;

	// ring successors
	assign wr_next = (wr_q == LAST_IDX) ? '0 : wr_q + IDX_ONE;
	assign rd_next = (rd_q == LAST_IDX) ? '0 : rd_q + IDX_ONE;

	// table lookup
	assign mods = '{shift: shift_q, ctrl: ctrl_q, caps: caps_q};

	sc2a_xlate u_xlate (
		.make_code (scan_byte[6:0]),
		.mods      (mods),
		.kc        (kc)
	);

	// codes allowed after the prefix byte
	assign ext_ok = (scan_byte[6:0] == EXT_ALT) || (scan_byte[6:0] == EXT_CTRL) ||
		(scan_byte[6:0] == EXT_KP_SLASH) || (scan_byte[6:0] == EXT_KP_ENTER);

	// next state of the keyboard tracker and the queue pointers
	always_comb begin
		prefix_d = prefix_q;
		shift_d  = shift_q;
		ctrl_d   = ctrl_q;
		alt_d    = alt_q;
		caps_d   = caps_q;
		num_d    = num_q;
		scroll_d = scroll_q;
		wr_d     = wr_q;
		rd_d     = rd_q;
		push     = 1'b0;
		pop      = 1'b0;
		drop     = 1'b0;
		ledup    = 1'b0;
		if (fire) begin
			if (op == OP_READ) begin
				if (wr_q != rd_q) begin
					pop  = 1'b1;
					rd_d = rd_next;
				end
			end else if (!rx_error && !from_aux) begin
				if (scan_byte == SC_PREFIX) begin
					prefix_d = 1'b1;
				end else begin
					prefix_d = 1'b0;
					if (!prefix_q || ext_ok) begin
						case (scan_byte)
							SC_LSHIFT, SC_RSHIFT: shift_d = 1'b1;
							SC_LSHIFT_BRK, SC_RSHIFT_BRK: shift_d = 1'b0;
							SC_ALT: alt_d = 1'b1;
							SC_ALT_BRK: alt_d = 1'b0;
							SC_CTRL: ctrl_d = 1'b1;
							SC_CTRL_BRK: ctrl_d = 1'b0;
							SC_SCROLL: begin
								scroll_d = ~scroll_q;
								ledup    = 1'b1;
							end
							SC_CAPS: begin
								caps_d = ~caps_q;
								ledup  = 1'b1;
							end
							SC_NUM: begin
								num_d = ~num_q;
								ledup = 1'b1;
							end
							SC_SCROLL_BRK, SC_NUM_BRK, SC_CAPS_BRK: begin
							end
							default: begin
								if (!scan_byte[7] && scan_byte < 8'(XLATE_LEN) &&
										kc != NO_CHAR) begin
									if (wr_next == rd_q) begin
										drop = 1'b1;
									end else begin
										push = 1'b1;
										wr_d = wr_next;
									end
								end
							end
						endcase
					end
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
			alt_q    <= 1'b0;
			caps_q   <= 1'b0;
			num_q    <= 1'b0;
			scroll_q <= 1'b0;
			wr_q     <= '0;
			rd_q     <= '0;
		end else begin
			prefix_q <= prefix_d;
			shift_q  <= shift_d;
			ctrl_q   <= ctrl_d;
			alt_q    <= alt_d;
			caps_q   <= caps_d;
			num_q    <= num_d;
			scroll_q <= scroll_d;
			wr_q     <= wr_d;
			rd_q     <= rd_d;
		end
	end

	// character store: push writes the new tail, pop reads the new head
	sc2a_ram #(
		.WIDTH (8),
		.DEPTH (QUEUE_DEPTH)
	) u_char_ram (
		.clk   (clk),
		.we    (push),
		.waddr (wr_next),
		.wdata (kc),
		.re    (pop),
		.raddr (rd_next),
		.rdata (ram_rdata)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded on each accepted transfer
	always_ff @(posedge clk) begin
		if (fire) begin
			char_valid_s1 <= pop;
			nonempty_s1   <= (wr_d != rd_d);
			dropped_s1    <= drop;
			ledup_s1      <= ledup;
			led_s1        <= {caps_d, num_d, scroll_d};
		end
	end

	// outputs
	assign result_valid   = out_valid_q;
	assign char_valid     = char_valid_s1;
	assign char_code      = char_valid_s1 ? ram_rdata : 8'h00;
	assign queue_nonempty = nonempty_s1;
	assign dropped_full   = dropped_s1;
	assign led_update     = ledup_s1;
	assign led_bits       = led_s1;

	// a pop on a non-empty queue delivers a character next cycle
	a_pop_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (op == OP_READ) && (wr_q != rd_q) |=> out_valid_q && char_valid_s1)
		else $error("pop on non-empty queue gave no character");

	// a drop only happens with a full queue, so characters remain
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && dropped_s1 |-> nonempty_s1)
		else $error("character dropped while queue not full");

	// a lock toggle never comes with a pop or a push attempt
	a_led_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ledup_s1 |-> !char_valid_s1 && !dropped_s1)
		else $error("led update mixed with queue activity");

	// pointers stay inside the ring
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_q <= LAST_IDX) && (rd_q <= LAST_IDX))
		else $error("queue pointer out of range");

endmodule
